// ===== rtl/core/esbc_pkg.sv =====
// Package for the encoder status and blink-code core.
// Holds the beat payload structs, the blink phase struct, flag positions and timing constants.
// No dependencies.
package esbc_pkg;

	// Input beat: one millisecond tick.
	typedef struct packed {
		logic        sensor_present;
		logic [7:0]  sensor_status;
		logic [11:0] sensor_angle;
		logic        crc_error;
		logic        is_enumerated;
		logic [7:0]  node_id;
	} in_t;

	// Output beat: one result per tick.
	typedef struct packed {
		logic        err_led;
		logic        stat_led;
		logic [4:0]  encoder_flags;
		logic [11:0] angle;
	} out_t;

	// Blink timing state handed to the LED logic.
	typedef struct packed {
		logic [9:0] startup_time;
		logic [3:0] err_idx;
		logic [7:0] err_pos;
		logic [4:0] stat_idx;
		logic [7:0] stat_pos;
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SAMPLE_PERIOD = 2'd0,
		REG_STALE_LIMIT   = 2'd1,
		REG_CRC_HOLD      = 2'd2
	} reg_idx_t;

	localparam logic [7:0]  SAMPLE_PERIOD_RST = 8'd2;
	localparam logic [15:0] STALE_LIMIT_RST   = 16'd50;
	localparam logic [15:0] CRC_HOLD_RST      = 16'd2000;

	// Encoder flag bit positions.
	localparam int FLAG_I2C_OK   = 0;
	localparam int FLAG_DETECTED = 1;
	localparam int FLAG_WEAK     = 2;
	localparam int FLAG_STRONG   = 3;
	localparam int FLAG_STALE    = 4;

	// Sensor status bit positions.
	localparam int STS_DETECTED = 5;
	localparam int STS_WEAK     = 4;
	localparam int STS_STRONG   = 3;

	localparam logic [4:0] FLAGS_RST = 5'b10000;

	// Pulse timing: 240 ms slot, on for the first 120 ms.
	localparam logic [7:0] PULSE_LAST = 8'd239;
	localparam logic [7:0] PULSE_ON   = 8'd120;

	// Error cycle of 2000 ms ends at slot 8, position 79.
	localparam logic [3:0] ERR_LAST_IDX = 4'd8;
	localparam logic [7:0] ERR_LAST_POS = 8'd79;

	// Status cycle of 5000 ms ends at slot 20, position 199.
	localparam logic [4:0] STAT_LAST_IDX = 5'd20;
	localparam logic [7:0] STAT_LAST_POS = 8'd199;

	// Startup double blink.
	localparam logic [9:0] STARTUP_END    = 10'd600;
	localparam logic [9:0] STARTUP_ON1_HI = 10'd120;
	localparam logic [9:0] STARTUP_ON2_LO = 10'd240;
	localparam logic [9:0] STARTUP_ON2_HI = 10'd360;

	// Error blink codes, value is the pulse count.
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_NO_MAGNET = 3'd1,
		ERR_WEAK      = 3'd2,
		ERR_STRONG    = 3'd3,
		ERR_CRC       = 3'd4,
		ERR_I2C       = 3'd5
	} err_code_t;

endpackage

// ===== rtl/core/encoder_status_blink_code_core.sv =====
// Top level of the encoder status and blink-code core.
// Holds the tick state and configuration; uses esbc_pkg, esbc_led and esbc_skid.
//
//  channel | signals                        | content
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data    | one millisecond tick per beat
//  out     | out_valid, out_ready, out_data | LED drive, flags, angle
//  cfg     | cfg_wen, cfg_index, cfg_data   | register write, no read-back
//
// Each input beat is evaluated in the cycle it is accepted and its result is
// registered, so one beat per cycle is sustained while the output buffer has room.
// A two-entry output buffer keeps input open while one result waits; input
// stalls only when both entries are held. Reset clears the tick state, sets
// the flags to their reset value and loads the register defaults.
module encoder_status_blink_code_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  esbc_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output esbc_pkg::out_t  out_data,
	input  logic            cfg_wen,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	// Configuration registers.
	logic [7:0]  sample_period_q;
	logic [15:0] stale_limit_q;
	logic [15:0] crc_hold_q;

	// Tick state.
	esbc_pkg::phase_t phase_q;
	logic [15:0] good_age_q;
	logic [7:0]  sample_age_q;
	logic [15:0] crc_rem_q;
	logic [4:0]  flags_q;
	logic [11:0] angle_q;

	logic             in_fire;
	logic             buf_full;
	logic [15:0]      crc_base;
	logic             sample_due;
	logic             detected;
	logic [4:0]       flags_new;
	logic [11:0]      angle_new;
	logic [15:0]      good_age_smp;
	esbc_pkg::out_t   result;
	esbc_pkg::phase_t phase_next;
	logic             err_wrap;
	logic             stat_wrap;

	assign in_ready = !buf_full;
	assign in_fire  = in_valid && in_ready;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= esbc_pkg::SAMPLE_PERIOD_RST;
			stale_limit_q   <= esbc_pkg::STALE_LIMIT_RST;
			crc_hold_q      <= esbc_pkg::CRC_HOLD_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				esbc_pkg::REG_SAMPLE_PERIOD: sample_period_q <= cfg_data[7:0];
				esbc_pkg::REG_STALE_LIMIT:   stale_limit_q   <= cfg_data;
				esbc_pkg::REG_CRC_HOLD:      crc_hold_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// CRC hold restarts on an error in this tick.
	assign crc_base   = in_data.crc_error ? crc_hold_q : crc_rem_q;
	assign sample_due = (sample_age_q == 8'd0);
	assign detected   = in_data.sensor_status[esbc_pkg::STS_DETECTED];

	// Sensor sample: flags, angle latch and good-sample age.
	always_comb begin
		flags_new    = flags_q;
		angle_new    = angle_q;
		good_age_smp = good_age_q;
		if (sample_due) begin
			if (!in_data.sensor_present) begin
				flags_new = esbc_pkg::FLAGS_RST;
			end else begin
				if (detected) begin
					angle_new    = in_data.sensor_angle;
					good_age_smp = 16'd0;
				end
				flags_new[esbc_pkg::FLAG_I2C_OK]   = 1'b1;
				flags_new[esbc_pkg::FLAG_DETECTED] = detected;
				flags_new[esbc_pkg::FLAG_WEAK]     =
					in_data.sensor_status[esbc_pkg::STS_WEAK];
				flags_new[esbc_pkg::FLAG_STRONG]   =
					in_data.sensor_status[esbc_pkg::STS_STRONG];
				flags_new[esbc_pkg::FLAG_STALE]    = good_age_smp > stale_limit_q;
			end
		end
	end

	esbc_led u_led (
		.phase         (phase_q),
		.flags         (flags_new),
		.crc_active    (crc_base != 16'd0),
		.is_enumerated (in_data.is_enumerated),
		.node_id       (in_data.node_id),
		.err_led       (result.err_led),
		.stat_led      (result.stat_led)
	);

	assign result.encoder_flags = flags_new;
	assign result.angle         = angle_new;

	// Blink phase advance: startup time, slot position and slot index per accepted beat.
	assign err_wrap  = (phase_q.err_idx == esbc_pkg::ERR_LAST_IDX) &&
		(phase_q.err_pos == esbc_pkg::ERR_LAST_POS);
	assign stat_wrap = (phase_q.stat_idx == esbc_pkg::STAT_LAST_IDX) &&
		(phase_q.stat_pos == esbc_pkg::STAT_LAST_POS);

	always_comb begin
		phase_next = phase_q;
		if (phase_q.startup_time < esbc_pkg::STARTUP_END) begin
			phase_next.startup_time = phase_q.startup_time + 10'd1;
		end
		if (err_wrap) begin
			phase_next.err_idx = 4'd0;
			phase_next.err_pos = 8'd0;
		end else if (phase_q.err_pos == esbc_pkg::PULSE_LAST) begin
			phase_next.err_idx = phase_q.err_idx + 4'd1;
			phase_next.err_pos = 8'd0;
		end else begin
			phase_next.err_pos = phase_q.err_pos + 8'd1;
		end
		if (stat_wrap) begin
			phase_next.stat_idx = 5'd0;
			phase_next.stat_pos = 8'd0;
		end else if (phase_q.stat_pos == esbc_pkg::PULSE_LAST) begin
			phase_next.stat_idx = phase_q.stat_idx + 5'd1;
			phase_next.stat_pos = 8'd0;
		end else begin
			phase_next.stat_pos = phase_q.stat_pos + 8'd1;
		end
	end

	// Tick state update on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			good_age_q   <= 16'd0;
			sample_age_q <= 8'd0;
			crc_rem_q    <= 16'd0;
			flags_q      <= esbc_pkg::FLAGS_RST;
			angle_q      <= 12'd0;
		end else if (in_fire) begin
			phase_q <= phase_next;
			flags_q <= flags_new;
			angle_q <= angle_new;
			if (good_age_smp != 16'hFFFF) begin
				good_age_q <= good_age_smp + 16'd1;
			end else begin
				good_age_q <= good_age_smp;
			end
			if (({1'b0, sample_age_q} + 9'd1) >= {1'b0, sample_period_q}) begin
				sample_age_q <= 8'd0;
			end else begin
				sample_age_q <= sample_age_q + 8'd1;
			end
			if (crc_base != 16'd0) begin
				crc_rem_q <= crc_base - 16'd1;
			end else begin
				crc_rem_q <= 16'd0;
			end
		end
	end

	esbc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_data (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/esbc_led.sv =====
// LED drive logic for the encoder status and blink-code core.
// Picks the error code by priority and forms both blink patterns.
// Depends on esbc_pkg.
module esbc_led (
	input  esbc_pkg::phase_t phase,
	input  logic [4:0]       flags,
	input  logic             crc_active,
	input  logic             is_enumerated,
	input  logic [7:0]       node_id,
	output logic             err_led,
	output logic             stat_led
);

	esbc_pkg::err_code_t err_code;
	logic                startup;
	logic                startup_on;
	logic [7:0]          pulses;

	// Error code priority: crc, i2c, no magnet, weak, strong.
	always_comb begin
		if (crc_active) begin
			err_code = esbc_pkg::ERR_CRC;
		end else if (!flags[esbc_pkg::FLAG_I2C_OK]) begin
			err_code = esbc_pkg::ERR_I2C;
		end else if (!flags[esbc_pkg::FLAG_DETECTED]) begin
			err_code = esbc_pkg::ERR_NO_MAGNET;
		end else if (flags[esbc_pkg::FLAG_WEAK]) begin
			err_code = esbc_pkg::ERR_WEAK;
		end else if (flags[esbc_pkg::FLAG_STRONG]) begin
			err_code = esbc_pkg::ERR_STRONG;
		end else begin
			err_code = esbc_pkg::ERR_NONE;
		end
	end

	// Startup double blink during the first 600 ms.
	assign startup    = phase.startup_time < esbc_pkg::STARTUP_END;
	assign startup_on = (phase.startup_time < esbc_pkg::STARTUP_ON1_HI) ||
		((phase.startup_time >= esbc_pkg::STARTUP_ON2_LO) &&
		 (phase.startup_time < esbc_pkg::STARTUP_ON2_HI));

	// Node id 255 wraps to zero pulses.
	assign pulses = node_id + 8'd1;

	// A pulse is lit while its slot is below the count and in its first half.
	always_comb begin
		if (startup) begin
			err_led  = startup_on;
			stat_led = startup_on;
		end else begin
			err_led  = (err_code != esbc_pkg::ERR_NONE) &&
				(phase.err_idx < {1'b0, err_code}) &&
				(phase.err_pos < esbc_pkg::PULSE_ON);
			stat_led = (err_code == esbc_pkg::ERR_NONE) && is_enumerated &&
				({3'b000, phase.stat_idx} < pulses) &&
				(phase.stat_pos < esbc_pkg::PULSE_ON);
		end
	end

endmodule

// ===== rtl/core/esbc_skid.sv =====
// Two-entry output buffer for the encoder status and blink-code core.
// Lets a new beat enter while a finished result waits. Depends on esbc_pkg.
module esbc_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  esbc_pkg::out_t   push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output esbc_pkg::out_t   out_data
);

	logic           out_valid_q;
	logic           skid_valid_q;
	esbc_pkg::out_t out_q;
	esbc_pkg::out_t skid_q;
	logic           pop;

	assign pop       = out_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Valid flags; a push only happens while the skid entry is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	// Payload moves without reset.
	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule

// ===== sim/esbc_tick_checker.sv =====
// Checker for the encoder status and blink-code core: watches all three channels,
// keeps its own model of the tick state and compares every result beat.
// Depends on esbc_pkg.
`timescale 1ns / 100ps

module esbc_tick_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  esbc_pkg::in_t   in_data,
	input  logic            out_valid,
	input  logic            out_ready,
	input  esbc_pkg::out_t  out_data,
	input  logic            cfg_wen,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	output int              mismatches,
	output int              pending
);

	localparam int PULSE_SLOT = 240;
	localparam int PULSE_HALF = 120;
	localparam int ERR_CYCLE  = 2000;
	localparam int STAT_CYCLE = 5000;

	// Register copies.
	logic [7:0]  period_ms;
	logic [15:0] stale_ms;
	logic [15:0] crc_hold;

	// Tick state of the model.
	logic [9:0]  startup_ms;
	logic [10:0] err_ph;
	logic [12:0] stat_ph;
	logic [15:0] good_age;
	logic [7:0]  smp_age;
	logic [15:0] crc_left;
	logic [4:0]  flags;
	logic [11:0] angle_hold;

	esbc_pkg::out_t predicted_beats[$];
	int             reported = 0;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// A pulse train of n pulses: 120 ms on, 120 ms off, from phase zero.
	function automatic logic pulse_on(input int ph, input int n);
		return (ph < n * PULSE_SLOT) && ((ph % PULSE_SLOT) < PULSE_HALF);
	endfunction

	// Works out the result of one tick and advances the model state.
	function automatic esbc_pkg::out_t predict_tick(input esbc_pkg::in_t t);
		esbc_pkg::err_code_t code;
		logic [7:0]          pulses;
		logic [4:0]          f;
		esbc_pkg::out_t      r;
		code = esbc_pkg::ERR_NONE;
		r = '0;
		if (t.crc_error)
			crc_left = crc_hold;

		// Sample the sensor when the period counter is at zero.
		if (smp_age == 8'd0) begin
			f = '0;
			if (!t.sensor_present) begin
				f[esbc_pkg::FLAG_STALE] = 1'b1;
			end else begin
				f[esbc_pkg::FLAG_I2C_OK]   = 1'b1;
				f[esbc_pkg::FLAG_DETECTED] = t.sensor_status[esbc_pkg::STS_DETECTED];
				f[esbc_pkg::FLAG_WEAK]     = t.sensor_status[esbc_pkg::STS_WEAK];
				f[esbc_pkg::FLAG_STRONG]   = t.sensor_status[esbc_pkg::STS_STRONG];
				if (f[esbc_pkg::FLAG_DETECTED]) begin
					angle_hold = t.sensor_angle;
					good_age = '0;
				end
				if (good_age > stale_ms)
					f[esbc_pkg::FLAG_STALE] = 1'b1;
			end
			flags = f;
		end
		if (int'(smp_age) + 1 >= int'(period_ms))
			smp_age = '0;
		else
			smp_age = smp_age + 8'd1;

		// LED drive: startup double blink, then error code or status pulses.
		if (startup_ms < esbc_pkg::STARTUP_END) begin
			r.err_led = (startup_ms < esbc_pkg::STARTUP_ON1_HI) ||
				(startup_ms >= esbc_pkg::STARTUP_ON2_LO &&
				 startup_ms < esbc_pkg::STARTUP_ON2_HI);
			r.stat_led = r.err_led;
		end else begin
			if (crc_left != 16'd0)
				code = esbc_pkg::ERR_CRC;
			else if (!flags[esbc_pkg::FLAG_I2C_OK])
				code = esbc_pkg::ERR_I2C;
			else if (!flags[esbc_pkg::FLAG_DETECTED])
				code = esbc_pkg::ERR_NO_MAGNET;
			else if (flags[esbc_pkg::FLAG_WEAK])
				code = esbc_pkg::ERR_WEAK;
			else if (flags[esbc_pkg::FLAG_STRONG])
				code = esbc_pkg::ERR_STRONG;
			r.err_led = (code != esbc_pkg::ERR_NONE) &&
				pulse_on(int'(err_ph), int'(code));
			pulses = t.node_id + 8'd1;
			r.stat_led = (code == esbc_pkg::ERR_NONE) && t.is_enumerated &&
				pulse_on(int'(stat_ph), int'(pulses));
		end
		r.encoder_flags = flags;
		r.angle = angle_hold;

		// Advance the counters.
		if (startup_ms < esbc_pkg::STARTUP_END)
			startup_ms = startup_ms + 10'd1;
		err_ph = (int'(err_ph) == ERR_CYCLE - 1) ? '0 : err_ph + 11'd1;
		stat_ph = (int'(stat_ph) == STAT_CYCLE - 1) ? '0 : stat_ph + 13'd1;
		if (good_age != 16'hFFFF)
			good_age = good_age + 16'd1;
		if (crc_left != 16'd0)
			crc_left = crc_left - 16'd1;
		return r;
	endfunction

	// Follow register writes, predict accepted ticks, check result beats.
	always @(posedge clk or negedge arst_n) begin
		esbc_pkg::out_t want;
		if (!arst_n) begin
			period_ms  = esbc_pkg::SAMPLE_PERIOD_RST;
			stale_ms   = esbc_pkg::STALE_LIMIT_RST;
			crc_hold   = esbc_pkg::CRC_HOLD_RST;
			startup_ms = '0;
			err_ph     = '0;
			stat_ph    = '0;
			good_age   = '0;
			smp_age    = '0;
			crc_left   = '0;
			flags      = esbc_pkg::FLAGS_RST;
			angle_hold = '0;
			predicted_beats.delete();
		end else begin
			if (cfg_wen) begin
				case (esbc_pkg::reg_idx_t'(cfg_index))
					esbc_pkg::REG_SAMPLE_PERIOD: period_ms = cfg_data[7:0];
					esbc_pkg::REG_STALE_LIMIT:   stale_ms = cfg_data;
					esbc_pkg::REG_CRC_HOLD:      crc_hold = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predicted_beats.push_back(predict_tick(in_data));
			if (out_valid && out_ready) begin
				if (predicted_beats.size() == 0) begin
					mismatches++;
					if (reported < 10) begin
						reported++;
						$display("%0t: unexpected beat: err=%0b stat=%0b flags=%02h angle=%03h",
							$realtime, out_data.err_led, out_data.stat_led,
							out_data.encoder_flags, out_data.angle);
					end
				end else begin
					want = predicted_beats.pop_front();
					if (out_data.err_led !== want.err_led ||
						out_data.stat_led !== want.stat_led ||
						out_data.encoder_flags !== want.encoder_flags ||
						out_data.angle !== want.angle) begin
						mismatches++;
						if (reported < 10) begin
							reported++;
							$display("%0t: expected err=%0b stat=%0b flags=%02h angle=%03h",
								$realtime, want.err_led, want.stat_led,
								want.encoder_flags, want.angle);
							$display("%0t: got      err=%0b stat=%0b flags=%02h angle=%03h",
								$realtime, out_data.err_led, out_data.stat_led,
								out_data.encoder_flags, out_data.angle);
						end
					end
				end
			end
		end
		pending = predicted_beats.size();
	end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the encoder status and blink-code core: makes tick stimulus,
// register settings and output stalls, and gives the verdict.
// Depends on esbc_pkg, encoder_status_blink_code_core and esbc_tick_checker.
`timescale 1ns / 100ps

module tb;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SEGMENT     = 160;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	esbc_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	esbc_pkg::out_t out_data;
	logic           cfg_wen = 1'b0;
	logic [1:0]     cfg_index = '0;
	logic [15:0]    cfg_data = '0;
	int             mismatches;
	int             pending;

	// Pacing shared by the sender and the receiver.
	bit calm = 1'b0;
	int hold_asks = 0;

	// Sensor scene that random ticks follow; it changes now and then.
	logic       scene_present = 1'b1;
	logic       scene_det = 1'b1;
	logic       scene_weak = 1'b0;
	logic       scene_strong = 1'b0;
	logic       scene_enum = 1'b1;
	logic [7:0] scene_node = 8'd2;
	bit         scene_locked = 1'b0;

	// Opening ticks: field extremes and each sensor condition.
	esbc_pkg::in_t opening_ticks [12] = '{
		'{1'b0, 8'hFF, 12'hFFF, 1'b1, 1'b1, 8'hFF},
		'{1'b1, 8'h00, 12'h000, 1'b0, 1'b0, 8'h00},
		'{1'b1, 8'h20, 12'hFFF, 1'b0, 1'b1, 8'h00},
		'{1'b1, 8'h30, 12'h123, 1'b0, 1'b1, 8'h01},
		'{1'b1, 8'h28, 12'hABC, 1'b0, 1'b1, 8'h13},
		'{1'b1, 8'h38, 12'h555, 1'b0, 1'b1, 8'h14},
		'{1'b1, 8'hFF, 12'hAAA, 1'b0, 1'b1, 8'hFE},
		'{1'b1, 8'hDF, 12'h0FF, 1'b0, 1'b1, 8'hFF},
		'{1'b0, 8'h20, 12'h777, 1'b0, 1'b1, 8'hFF},
		'{1'b1, 8'hC7, 12'h800, 1'b1, 1'b0, 8'h80},
		'{1'b1, 8'h20, 12'h001, 1'b1, 1'b1, 8'h7F},
		'{1'b1, 8'h00, 12'hF00, 1'b0, 1'b1, 8'h00}
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	encoder_status_blink_code_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	esbc_tick_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Offers one tick beat and waits until it is taken, then maybe idles.
	task automatic send_tick(input esbc_pkg::in_t t);
		in_data <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (!calm && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 29);
		end
	endtask

	// Stops offering and waits until every result beat has come back.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes all three registers on back-to-back cycles while the core is idle.
	task automatic apply_settings(input logic [7:0] period, input logic [15:0] stale,
		input logic [15:0] hold);
		drain();
		cfg_wen <= 1'b1;
		cfg_index <= esbc_pkg::REG_SAMPLE_PERIOD;
		cfg_data <= {8'd0, period};
		@(posedge clk);
		cfg_index <= esbc_pkg::REG_STALE_LIMIT;
		cfg_data <= stale;
		@(posedge clk);
		cfg_index <= esbc_pkg::REG_CRC_HOLD;
		cfg_data <= hold;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Draws the next tick from the current scene, with some pure noise.
	task automatic next_tick(output esbc_pkg::in_t t);
		int mode;
		if (!scene_locked && $urandom_range(0, 149) == 0) begin
			mode = $urandom_range(0, 9);
			scene_present = (mode != 0);
			scene_det = (mode >= 2);
			scene_weak = (mode == 2 || mode == 4);
			scene_strong = (mode == 3 || mode == 4);
			scene_enum = ($urandom_range(0, 7) != 0);
			case ($urandom_range(0, 7))
				0: scene_node = 8'hFF;
				1: scene_node = 8'($urandom_range(0, 255));
				default: scene_node = 8'($urandom_range(0, 20));
			endcase
		end
		t.sensor_present = scene_present;
		t.sensor_status = 8'($urandom_range(0, 255));
		t.sensor_status[esbc_pkg::STS_DETECTED] = scene_det;
		t.sensor_status[esbc_pkg::STS_WEAK] = scene_weak;
		t.sensor_status[esbc_pkg::STS_STRONG] = scene_strong;
		t.sensor_angle = 12'($urandom_range(0, 4095));
		t.crc_error = ($urandom_range(0, 299) == 0);
		t.is_enumerated = scene_enum;
		t.node_id = scene_node;
		if (!scene_locked && $urandom_range(0, 19) == 0)
			t = esbc_pkg::in_t'(31'($urandom));
	endtask

	task automatic run_ticks(input int n);
		esbc_pkg::in_t t;
		repeat (n) begin
			next_tick(t);
			send_tick(t);
		end
	endtask

	// Receiver: random stalls, calm stretches and a long hold on each request.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 29);
			end
		end
	end

	// Watchdog: ends the run when no beat moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening ticks sample on every tick, with a period of zero.
		apply_settings(8'd0, 16'd50, 16'd2000);
		foreach (opening_ticks[i])
			send_tick(opening_ticks[i]);

		// Random segments under several settings, extremes among them.
		apply_settings(esbc_pkg::SAMPLE_PERIOD_RST, esbc_pkg::STALE_LIMIT_RST,
			esbc_pkg::CRC_HOLD_RST);
		run_ticks(SEGMENT);
		apply_settings(8'd0, 16'd0, 16'd0);
		run_ticks(SEGMENT);
		apply_settings(8'd255, 16'hFFFF, 16'hFFFF);
		hold_asks++;
		run_ticks(SEGMENT);
		apply_settings(8'd1, 16'd1, 16'd1);
		run_ticks(SEGMENT);
		apply_settings(8'd7, 16'd30, 16'd300);
		calm = 1'b1;
		run_ticks(SEGMENT);
		calm = 1'b0;
		apply_settings(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 3000)));
		run_ticks(SEGMENT);
		apply_settings(8'd3, 16'd200, 16'd500);
		hold_asks++;
		run_ticks(SEGMENT);

		// Lower the period below the running sample count.
		apply_settings(8'd200, 16'd100, 16'd50);
		run_ticks(60);
		apply_settings(8'd5, 16'd100, 16'd50);
		run_ticks(40);

		// A stretch without a magnet under wide stale limits, then it returns.
		apply_settings(8'd1, 16'hFFFF, 16'd2000);
		scene_locked = 1'b1;
		scene_present = 1'b1;
		scene_det = 1'b0;
		calm = 1'b1;
		run_ticks(50);
		apply_settings(8'd1, 16'hFFFE, 16'd2000);
		run_ticks(50);
		scene_det = 1'b1;
		scene_weak = 1'b0;
		scene_strong = 1'b0;
		run_ticks(20);
		scene_locked = 1'b0;
		calm = 1'b0;
		run_ticks(100);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== encoder_status_blink_code_core.f =====
rtl/core/esbc_pkg.sv
rtl/core/esbc_led.sv
rtl/core/esbc_skid.sv
rtl/core/encoder_status_blink_code_core.sv
sim/esbc_tick_checker.sv
sim/tb.sv
